// ===== rtl/swrq_pkg.sv =====
// Shared types and constants for the split work-stealing ring queue.
// Used by the ALU and the top level; depends on nothing else.
package swrq_pkg;

    // Ring geometry and fixed field widths.
    localparam int SLOTS    = 1024;
    localparam int ADDR_W   = 10;
    localparam int CNT_W    = 11;
    localparam int CMD_W    = 4;
    localparam int STAT_W   = 2;
    localparam int DATA_W   = 64;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH        = 4'd0;
    localparam logic [CMD_W-1:0] CMD_POP         = 4'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REACQUIRE   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_STEAL       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_READ_SLOT   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_COPY_DONE   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_RECLAIM     = 4'd8;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_WAIT     = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

    // Operations of the shared modular adder.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

// ===== rtl/swrq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
module swrq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/swrq_alu.sv =====
// Shared modular adder/subtractor: all ring pointer arithmetic runs through it.
// Depends on swrq_pkg.
module swrq_alu
    import swrq_pkg::*;
(
    input  alu_op_t          op,
    input  logic [CNT_W-1:0] a,
    input  logic [CNT_W-1:0] b,
    input  logic [CNT_W-1:0] capacity,
    output logic [CNT_W-1:0] y
);

    logic [CNT_W:0] sum;
    logic [CNT_W:0] diff;

    // Operands are below capacity, so one correction step reduces the result.
    always_comb
    begin
        sum  = {1'b0, a} + {1'b0, b};
        diff = {1'b0, a} - {1'b0, b};
        unique case (op)
            ALU_ADD:
            begin
                if (sum >= {1'b0, capacity})
                begin
                    sum = sum - {1'b0, capacity};
                end
                y = sum[CNT_W-1:0];
            end
            ALU_SUB:
            begin
                if (a < b)
                begin
                    diff = diff + {1'b0, capacity};
                end
                y = diff[CNT_W-1:0];
            end
        endcase
    end

endmodule

// ===== rtl/split_work_stealing_ring_queue.sv =====
// Split work-stealing ring queue: local, shared and reserved parts of one ring.
// Each command passes S_SH, S_PUB, S_EXEC, its own steps and S_FIN; read slot is longest
// (10 steps of the shared modular adder).
// Throughput: one command at a time; the shared adder sets the step count.
// Reset clears the ring pointers and the local count and sets capacity to SLOTS; ring
// contents are undefined until written. Depends on swrq_pkg, swrq_alu, swrq_ram.
module split_work_stealing_ring_queue
    import swrq_pkg::*;
#(
    parameter int ELEM_WIDTH = DATA_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [10:0]   cfg_wdata,      // capacity
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [87:0]   s_axis_tdata,   // elem_data[63:0], count[74:64], slot_index[84:75]
    input  logic [4:0]    s_axis_tuser,   // cmd[3:0], steal_mode[4]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // data_out[63:0], amount[74:64], start_slot[84:75],
                                          // local_count[95:85], shared_count[106:96]
    output logic [1:0]    m_axis_tuser    // status
);

    typedef enum logic [3:0] {
        S_IDLE, S_SH, S_PUB, S_EXEC, S_RACQ, S_POPADDR, S_RECL, S_PUSHADDR,
        S_RELS, S_STEAL, S_PEND, S_INFL, S_MOD, S_RD, S_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cap_reg, cap_next;
    logic [CNT_W-1:0]   lc_reg, lc_next;
    logic [ADDR_W-1:0]  split_reg, split_next;
    logic [ADDR_W-1:0]  tail_reg, tail_next;
    logic [ADDR_W-1:0]  infl_reg, infl_next;
    logic [ADDR_W-1:0]  resv_reg, resv_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [ELEM_WIDTH-1:0] elem_reg, elem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               mode_reg, mode_next;
    logic [ADDR_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]   sh_reg, sh_next;
    logic [CNT_W-1:0]   pub_reg, pub_next;
    logic [CNT_W-1:0]   amt_reg, amt_next;
    logic [STAT_W-1:0]  stat_reg, stat_next;
    logic [ADDR_W-1:0]  start_reg, start_next;
    logic [ELEM_WIDTH-1:0] data_reg, data_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [3:0]         bit_reg, bit_next;
    logic               mval_reg, mval_next;
    logic [111:0]       mdata_reg, mdata_next;
    logic [1:0]         muser_reg, muser_next;

    alu_op_t            alu_op;
    logic [CNT_W-1:0]   alu_a, alu_b, alu_y;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [ELEM_WIDTH-1:0] ram_rdata;

    logic [CNT_W:0]     lc_pub, lc_sh;
    logic [CNT_W-1:0]   diff, half, room, want, steal_n;
    logic               reclaim_ok;
    logic [CNT_W-1:0]   cap_clamped;

    swrq_alu u_alu (
        .op       (alu_op),
        .a        (alu_a),
        .b        (alu_b),
        .capacity (cap_reg),
        .y        (alu_y)
    );

    swrq_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (SLOTS)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (elem_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = muser_reg;

    // Operand selection for the shared adder, one use per sequencer step.
    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, split_reg};
        alu_b  = {1'b0, tail_reg};
        unique case (state_reg)
            S_PUB:
            begin
                alu_b = {1'b0, resv_reg};
            end
            S_RACQ:
            begin
                alu_b = amt_reg;
            end
            S_POPADDR:
            begin
                alu_op = ALU_ADD;
                alu_b  = lc_reg - 11'd1;
            end
            S_RECL:
            begin
                alu_a = {1'b0, tail_reg};
                alu_b = {1'b0, resv_reg};
            end
            S_PUSHADDR:
            begin
                alu_op = ALU_ADD;
                alu_b  = lc_reg;
            end
            S_RELS:
            begin
                alu_op = ALU_ADD;
                alu_b  = amt_reg;
            end
            S_STEAL:
            begin
                alu_op = ALU_ADD;
                alu_a  = {1'b0, tail_reg};
                alu_b  = amt_reg;
            end
            S_PEND:
            begin
                alu_a = {1'b0, tail_reg};
                alu_b = {1'b0, infl_reg};
            end
            S_INFL:
            begin
                alu_op = ALU_ADD;
                alu_a  = {1'b0, infl_reg};
                alu_b  = amt_reg;
            end
            S_MOD:
            begin
                alu_op = ALU_ADD;
                alu_a  = rem_reg;
                alu_b  = rem_reg + {10'd0, slot_reg[bit_reg]};
            end
            default:
            begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    // Small derived quantities used in the dispatch step and by the capacity write.
    always_comb
    begin
        lc_pub     = {1'b0, lc_reg} + {1'b0, pub_reg};
        lc_sh      = {1'b0, lc_reg} + {1'b0, sh_reg};
        diff       = sh_reg - lc_reg;
        half       = (lc_reg >> 1) + {10'd0, lc_reg[0]};
        room       = cap_reg - 11'd1 - pub_reg;
        want       = (cmd_reg == CMD_RELEASE) ? half : lc_reg;
        steal_n    = mode_reg ? sh_reg : (sh_reg >> 1) + {10'd0, sh_reg[0]};
        if (cnt_reg < steal_n)
        begin
            steal_n = cnt_reg;
        end
        reclaim_ok = (resv_reg != tail_reg) && (infl_reg == tail_reg);
        if (cfg_wdata < 11'd2)
        begin
            cap_clamped = 11'd2;
        end
        else if (cfg_wdata > CNT_W'(SLOTS))
        begin
            cap_clamped = CNT_W'(SLOTS);
        end
        else
        begin
            cap_clamped = cfg_wdata;
        end
    end

    // Command sequencer.
    always_comb
    begin
        state_next = state_reg;
        cap_next   = cap_reg;
        lc_next    = lc_reg;
        split_next = split_reg;
        tail_next  = tail_reg;
        infl_next  = infl_reg;
        resv_next  = resv_reg;
        cmd_next   = cmd_reg;
        elem_next  = elem_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        slot_next  = slot_reg;
        sh_next    = sh_reg;
        pub_next   = pub_reg;
        amt_next   = amt_reg;
        stat_next  = stat_reg;
        start_next = start_reg;
        data_next  = data_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = alu_y[ADDR_W-1:0];
        ram_raddr  = alu_y[ADDR_W-1:0];

        // The result register frees once its transfer completes.
        if (mval_reg && m_axis_tready)
        begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = s_axis_tuser[3:0];
                    mode_next  = s_axis_tuser[4];
                    elem_next  = s_axis_tdata[ELEM_WIDTH-1:0];
                    cnt_next   = s_axis_tdata[74:64];
                    slot_next  = s_axis_tdata[84:75];
                    amt_next   = '0;
                    stat_next  = ST_OK;
                    start_next = '0;
                    data_next  = '0;
                    state_next = S_SH;
                end
            end
            S_SH:
            begin
                sh_next    = alu_y;
                state_next = S_PUB;
            end
            S_PUB:
            begin
                pub_next   = alu_y;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                unique case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (lc_pub == {1'b0, cap_reg})
                        begin
                            if (lc_sh == {1'b0, cap_reg})
                            begin
                                stat_next = ST_OVERFLOW;
                            end
                            else if (reclaim_ok)
                            begin
                                state_next = S_RECL;
                            end
                            else
                            begin
                                stat_next = ST_WAIT;
                            end
                        end
                        else
                        begin
                            state_next = S_PUSHADDR;
                        end
                    end
                    CMD_POP, CMD_REACQUIRE:
                    begin
                        if (cmd_reg == CMD_POP && lc_reg != '0)
                        begin
                            state_next = S_POPADDR;
                        end
                        else if (sh_reg > lc_reg)
                        begin
                            amt_next   = (diff >> 1) + {10'd0, diff[0]};
                            lc_next    = lc_reg + (diff >> 1) + {10'd0, diff[0]};
                            state_next = S_RACQ;
                        end
                        else if (cmd_reg == CMD_POP)
                        begin
                            stat_next = ST_EMPTY;
                        end
                    end
                    CMD_RELEASE, CMD_RELEASE_ALL:
                    begin
                        if (cmd_reg == CMD_RELEASE_ALL || (lc_reg != '0 && sh_reg == '0))
                        begin
                            amt_next   = (want < room) ? want : room;
                            lc_next    = lc_reg - ((want < room) ? want : room);
                            state_next = S_RELS;
                        end
                    end
                    CMD_STEAL:
                    begin
                        if (steal_n != '0)
                        begin
                            start_next = tail_reg;
                            amt_next   = steal_n;
                            state_next = S_STEAL;
                        end
                        else
                        begin
                            stat_next = ST_EMPTY;
                        end
                    end
                    CMD_READ_SLOT:
                    begin
                        rem_next   = '0;
                        bit_next   = 4'd9;
                        state_next = S_MOD;
                    end
                    CMD_COPY_DONE:
                    begin
                        state_next = S_PEND;
                    end
                    CMD_RECLAIM:
                    begin
                        if (reclaim_ok)
                        begin
                            state_next = S_RECL;
                        end
                        else if (resv_reg != tail_reg)
                        begin
                            stat_next = ST_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RACQ:
            begin
                split_next = alu_y[ADDR_W-1:0];
                state_next = (cmd_reg == CMD_POP) ? S_POPADDR : S_FIN;
            end
            S_POPADDR:
            begin
                ram_re     = 1'b1;
                lc_next    = lc_reg - 11'd1;
                state_next = S_RD;
            end
            S_RECL:
            begin
                amt_next   = alu_y;
                resv_next  = tail_reg;
                state_next = (cmd_reg == CMD_PUSH) ? S_PUSHADDR : S_FIN;
            end
            S_PUSHADDR:
            begin
                ram_we     = 1'b1;
                lc_next    = lc_reg + 11'd1;
                state_next = S_FIN;
            end
            S_RELS:
            begin
                split_next = alu_y[ADDR_W-1:0];
                state_next = S_FIN;
            end
            S_STEAL:
            begin
                tail_next  = alu_y[ADDR_W-1:0];
                state_next = S_FIN;
            end
            S_PEND:
            begin
                amt_next   = (cnt_reg < alu_y) ? cnt_reg : alu_y;
                state_next = S_INFL;
            end
            S_INFL:
            begin
                infl_next  = alu_y[ADDR_W-1:0];
                state_next = S_FIN;
            end
            S_MOD:
            begin
                // One remainder bit per step, most significant slot bit first.
                rem_next = alu_y;
                if (bit_reg == '0)
                begin
                    ram_re     = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    bit_next = bit_reg - 4'd1;
                end
            end
            S_RD:
            begin
                data_next  = ram_rdata;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Shared size is recomputed here since split or tail may have moved.
                if (!mval_reg || m_axis_tready)
                begin
                    mval_next  = 1'b1;
                    mdata_next = {5'd0, alu_y, lc_reg, start_reg, amt_reg,
                                  DATA_W'(data_reg)};
                    muser_next = stat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Capacity write empties the queue.
        if (cfg_we)
        begin
            cap_next   = cap_clamped;
            lc_next    = '0;
            split_next = '0;
            tail_next  = '0;
            infl_next  = '0;
            resv_next  = '0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg   <= CNT_W'(SLOTS);
            lc_reg    <= '0;
            split_reg <= '0;
            tail_reg  <= '0;
            infl_reg  <= '0;
            resv_reg  <= '0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            lc_reg    <= lc_next;
            split_reg <= split_next;
            tail_reg  <= tail_next;
            infl_reg  <= infl_next;
            resv_reg  <= resv_next;
            mval_reg  <= mval_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        elem_reg  <= elem_next;
        cnt_reg   <= cnt_next;
        mode_reg  <= mode_next;
        slot_reg  <= slot_next;
        sh_reg    <= sh_next;
        pub_reg   <= pub_next;
        amt_reg   <= amt_next;
        stat_reg  <= stat_next;
        start_reg <= start_next;
        data_reg  <= data_next;
        rem_reg   <= rem_next;
        bit_reg   <= bit_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

endmodule
